// ===== design/hpq_pkg.sv =====
// Shared constants, codes and handoff types of the heap priority queue.
`timescale 1ns / 1ps
`default_nettype none

package hpq_pkg;

  // Storage size and stored value width
  localparam int CAPACITY    = 1024;
  localparam int VALUE_WIDTH = 32;

  // Tree geometry: levels, counter, level index, position in a level, row, node index
  localparam int LVLS  = $clog2(CAPACITY + 1);
  localparam int CNT_W = LVLS;
  localparam int LVL_W = $clog2(LVLS);
  localparam int POS_W = LVLS - 1;
  localparam int ROW_W = (LVLS > 2) ? LVLS - 2 : 1;
  localparam int IDX_W = LVLS + 2;

  // Port field widths
  localparam int DATA_W       = 32;
  localparam int CNT_OUT_W    = 11;
  localparam int OUT_TDATA_W  = 80;
  localparam int OUT_TUSER_W  = 3;

  // Operation codes on in_tuser
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef logic [VALUE_WIDTH-1:0] val_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Work token handed from one level cell to the next
  typedef struct packed {
    logic             vld;
    logic             ins;      // 1: top-down insert, 0: sift down
    val_t             val;      // value carried downward
    logic [POS_W-1:0] pos;      // node position inside the level
    logic [CNT_W-1:0] tgt;      // insert: 1-based index of the new leaf
    logic [LVL_W-1:0] tgt_lvl;  // insert: level of the new leaf
  } tok_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic             en;
    logic             right;
    logic [ROW_W-1:0] addr;
    val_t             data;
  } wr_req_t;

endpackage

`default_nettype wire

// ===== design/hpq_ram.sv =====
// Simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module hpq_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/hpq_cell.sv =====
// One tree level cell: reads its node and children, writes its node, passes the token down.
`timescale 1ns / 1ps
`default_nettype none

module hpq_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [hpq_pkg::LVL_W-1:0]  lvl,
  input  wire logic [hpq_pkg::CNT_W-1:0]  count,
  input  wire hpq_pkg::tok_t              in_tok,
  input  wire hpq_pkg::val_t              own_l,
  input  wire hpq_pkg::val_t              own_r,
  input  wire hpq_pkg::val_t              kid_l,
  input  wire hpq_pkg::val_t              kid_r,
  output hpq_pkg::rd_req_t                own_rd,
  output hpq_pkg::rd_req_t                kid_rd,
  output hpq_pkg::wr_req_t                wr,
  output hpq_pkg::tok_t                   out_tok,
  output logic                            done
);

  import hpq_pkg::*;

  tok_t             tok_r;
  tok_t             out_tok_r;
  tok_t             out_tok_nxt;
  val_t             node_v;
  val_t             cand_v;
  logic [IDX_W-1:0] node_idx;
  logic [IDX_W-1:0] left_idx;
  logic [IDX_W-1:0] right_idx;
  logic [IDX_W-1:0] cnt_ext;
  logic             left_ok;
  logic             right_ok;
  logic             pick_right;
  logic             at_tgt;
  logic [LVL_W-1:0] bit_sel;
  logic [CNT_W-1:0] tgt_sh;
  logic             path_bit;

  function automatic logic gt(input val_t a, input val_t b);
    return $signed(a) > $signed(b);
  endfunction

  // Issue reads of own node row and, for a sift, child row as the token arrives
  always_comb begin
    own_rd.en   = in_tok.vld;
    own_rd.addr = ROW_W'(in_tok.pos >> 1);
    kid_rd.en   = in_tok.vld && !in_tok.ins;
    kid_rd.addr = ROW_W'(in_tok.pos);
  end

  // Hold the token while the read data comes back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r     <= '0;
      out_tok_r <= '0;
    end else begin
      tok_r     <= in_tok;
      out_tok_r <= out_tok_nxt;
    end
  end

  // Node and child geometry
  always_comb begin
    node_v     = tok_r.pos[0] ? own_r : own_l;
    node_idx   = (IDX_W'(1) << lvl) - IDX_W'(1) + IDX_W'(tok_r.pos);
    left_idx   = {node_idx[IDX_W-2:0], 1'b1};
    right_idx  = left_idx + IDX_W'(1);
    cnt_ext    = IDX_W'(count);
    left_ok    = left_idx < cnt_ext;
    right_ok   = right_idx < cnt_ext;
    pick_right = right_ok && gt(kid_r, kid_l);
    cand_v     = pick_right ? kid_r : kid_l;
    at_tgt     = tok_r.tgt_lvl == lvl;
    bit_sel    = tok_r.tgt_lvl - lvl - LVL_W'(1);
    tgt_sh     = tok_r.tgt >> bit_sel;
    path_bit   = tgt_sh[0];
  end

  // Decide the node write and the token handed to the next level
  always_comb begin
    wr          = '0;
    wr.addr     = ROW_W'(tok_r.pos >> 1);
    wr.right    = tok_r.pos[0];
    wr.data     = tok_r.val;
    done        = 1'b0;
    out_tok_nxt = '0;
    if (tok_r.vld) begin
      if (tok_r.ins) begin
        if (at_tgt) begin
          wr.en = 1'b1;
          done  = 1'b1;
        end else begin
          out_tok_nxt     = tok_r;
          out_tok_nxt.pos = POS_W'({tok_r.pos, path_bit});
          if (gt(tok_r.val, node_v)) begin
            wr.en           = 1'b1;
            out_tok_nxt.val = node_v;
          end
        end
      end else begin
        if (left_ok && gt(cand_v, tok_r.val)) begin
          wr.en           = 1'b1;
          wr.data         = cand_v;
          out_tok_nxt     = tok_r;
          out_tok_nxt.pos = POS_W'({tok_r.pos, pick_right});
        end else begin
          wr.en = 1'b1;
          done  = 1'b1;
        end
      end
    end
  end

  assign out_tok = out_tok_r;

endmodule

`default_nettype wire

// ===== design/max_heap_priority_queue_core.sv =====
// Top level of the binary max-heap priority queue: sequencer, level cells and level RAMs.
`timescale 1ns / 1ps
`default_nettype none

// Max-heap priority queue of signed values, one operation per input transfer
// (in_tuser 0 inserts in_tdata, 1 removes the maximum), one result transfer
// per operation. The tree is a chain of level cells, each owning the RAM of
// its level; a work token walks from the root toward the leaves, and at each
// level the cell first reads the RAM, then compares and writes. An insert
// walks from the root to the level of the new leaf. A remove first fetches
// the last element and then, unless the heap is now empty, sifts it down
// from the root. At the full size of 1024 entries (11 levels) the longest
// insert reaches level 10 and the longest remove descends 9 levels. The
// sequencer returns to idle, ready for the next input, as the result is
// posted. A refused operation (full or empty) goes straight to the response
// state with no tree walk. The next operation is accepted while the previous
// result still waits in the output register; a stalled output holds the
// sequencer only when the following result is ready.
// No clearing pass after reset: the queue is usable in the first cycle.
module max_heap_priority_queue_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [hpq_pkg::DATA_W-1:0]        in_tdata,   // [31:0] in_value
  input  wire logic                              in_tuser,   // [0] opcode
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [31:0] removed_value, [63:32] top_value, [74:64] element_count, [79:75] zero
  output logic      [hpq_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [0] top_valid, [2:1] status
  output logic      [hpq_pkg::OUT_TUSER_W-1:0]   out_tuser
);

  import hpq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_LAST = 5'b00100,
    S_SIFT = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  typedef struct packed {
    logic             en;
    logic [LVL_W-1:0] lvl;
    logic             half;
    logic [ROW_W-1:0] addr;
  } seq_rd_t;

  state_t                   state_r;
  logic [CNT_W-1:0]         count_r;
  val_t                     root_r;
  logic [DATA_W-1:0]        removed_r;
  status_t                  status_r;
  tok_t                     inj_r;
  seq_rd_t                  srd_r;
  logic                     out_vld_r;
  logic [OUT_TDATA_W-1:0]   out_data_r;
  logic [OUT_TUSER_W-1:0]   out_user_r;

  logic                     accept;
  logic                     out_free;
  logic [CNT_W-1:0]         ins_n;
  logic [LVL_W-1:0]         ins_lvl;
  logic [LVL_W-1:0]         rem_lvl;
  logic [POS_W-1:0]         rem_pos;
  val_t                     last_v;
  logic [DATA_W-1:0]        top_out;

  tok_t                     cell_in  [LVLS];
  tok_t                     cell_out [LVLS];
  rd_req_t                  own_rd   [LVLS];
  rd_req_t                  kid_rd   [LVLS];
  wr_req_t                  wr       [LVLS];
  val_t                     rd_l     [LVLS];
  val_t                     rd_r     [LVLS];
  logic [LVLS-1:0]          done_v;
  logic [LVLS-1:0]          busy_v;

  function automatic logic [LVL_W-1:0] msb_lvl(input logic [CNT_W-1:0] n);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (n[i]) begin
        r = LVL_W'(i);
      end
    end
    return r;
  endfunction

  function automatic val_t to_store(input logic [DATA_W-1:0] x);
    return VALUE_WIDTH'($signed(x));
  endfunction

  function automatic logic [DATA_W-1:0] to_out(input val_t v);
    return DATA_W'($signed(v));
  endfunction

  // Handshakes
  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_vld_r || out_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Path of a new leaf and place of the last element
  always_comb begin
    ins_n   = CNT_W'(count_r + CNT_W'(1));
    ins_lvl = msb_lvl(ins_n);
    rem_lvl = msb_lvl(count_r);
    rem_pos = POS_W'(count_r - (CNT_W'(1) << rem_lvl));
    last_v  = srd_r.half ? rd_r[srd_r.lvl] : rd_l[srd_r.lvl];
    top_out = (count_r != '0) ? to_out(root_r) : '0;
  end

  // Mirror of the root node, kept for the result
  always_ff @(posedge clk) begin
    if (wr[0].en) begin
      root_r <= wr[0].data;
    end
  end

  // Result valid: raise on the response, drop after its transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if ((state_r == S_RESP) && out_free) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  // Operation sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      inj_r      <= '0;
      srd_r      <= '0;
      removed_r  <= '0;
      status_r   <= ST_OK;
      out_data_r <= '0;
      out_user_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_tuser == OP_INSERT) begin
              removed_r <= '0;
              if (count_r == CNT_W'(CAPACITY)) begin
                status_r <= ST_FULL;
                state_r  <= S_RESP;
              end else begin
                status_r      <= ST_OK;
                count_r       <= ins_n;
                inj_r.vld     <= 1'b1;
                inj_r.ins     <= 1'b1;
                inj_r.val     <= to_store(in_tdata);
                inj_r.pos     <= '0;
                inj_r.tgt     <= ins_n;
                inj_r.tgt_lvl <= ins_lvl;
                state_r       <= S_SIFT;
              end
            end else begin
              if (count_r == '0) begin
                removed_r <= '0;
                status_r  <= ST_EMPTY;
                state_r   <= S_RESP;
              end else begin
                removed_r  <= to_out(root_r);
                status_r   <= ST_OK;
                count_r    <= CNT_W'(count_r - CNT_W'(1));
                srd_r.en   <= 1'b1;
                srd_r.lvl  <= rem_lvl;
                srd_r.half <= rem_pos[0];
                srd_r.addr <= ROW_W'(rem_pos >> 1);
                state_r    <= S_READ;
              end
            end
          end
        end
        S_READ: begin
          srd_r.en <= 1'b0;
          state_r  <= S_LAST;
        end
        S_LAST: begin
          if (count_r == '0) begin
            state_r <= S_RESP;
          end else begin
            inj_r.vld     <= 1'b1;
            inj_r.ins     <= 1'b0;
            inj_r.val     <= last_v;
            inj_r.pos     <= '0;
            inj_r.tgt     <= '0;
            inj_r.tgt_lvl <= '0;
            state_r       <= S_SIFT;
          end
        end
        S_SIFT: begin
          inj_r.vld <= 1'b0;
          if (|done_v) begin
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_data_r <= OUT_TDATA_W'({CNT_OUT_W'(count_r), top_out, removed_r});
            out_user_r <= {status_r, count_r != '0};
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // One cell and a pair of row RAMs per tree level, only a left RAM where the level holds one entry
  for (genvar k = 0; k < LVLS; k++) begin : g_lvl
    localparam int BASE = (1 << k) - 1;
    localparam int NENT = ((CAPACITY - BASE) < (1 << k)) ? (CAPACITY - BASE) : (1 << k);
    localparam int ROWS = (NENT + 1) / 2;
    localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    rd_req_t          kid_req;
    logic             seq_hit;
    logic             rd_en;
    logic [ROW_W-1:0] rd_addr;
    val_t             kid_l;
    val_t             kid_r;

    if (k == 0) begin : g_root
      assign kid_req    = '0;
      assign cell_in[k] = inj_r;
    end else begin : g_inner
      assign kid_req    = kid_rd[k-1];
      assign cell_in[k] = cell_out[k-1];
    end

    if (k < LVLS - 1) begin : g_kids
      assign kid_l = rd_l[k+1];
      assign kid_r = rd_r[k+1];
    end else begin : g_leaf
      assign kid_l = '0;
      assign kid_r = '0;
    end

    // Route the level's read port: own cell, parent cell or last-element fetch
    assign seq_hit = srd_r.en && (srd_r.lvl == LVL_W'(k));
    assign rd_en   = own_rd[k].en || kid_req.en || seq_hit;
    always_comb begin
      if (own_rd[k].en) begin
        rd_addr = own_rd[k].addr;
      end else if (kid_req.en) begin
        rd_addr = kid_req.addr;
      end else begin
        rd_addr = srd_r.addr;
      end
    end

    hpq_ram #(
      .DEPTH (ROWS),
      .WIDTH (VALUE_WIDTH),
      .AW    (AW)
    ) u_ram_l (
      .clk     (clk),
      .wr_en   (wr[k].en && !wr[k].right),
      .wr_addr (wr[k].addr[AW-1:0]),
      .wr_data (wr[k].data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr[AW-1:0]),
      .rd_data (rd_l[k])
    );

    if (NENT > 1) begin : g_right
      hpq_ram #(
        .DEPTH (ROWS),
        .WIDTH (VALUE_WIDTH),
        .AW    (AW)
      ) u_ram_r (
        .clk     (clk),
        .wr_en   (wr[k].en && wr[k].right),
        .wr_addr (wr[k].addr[AW-1:0]),
        .wr_data (wr[k].data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr[AW-1:0]),
        .rd_data (rd_r[k])
      );
    end else begin : g_no_right
      assign rd_r[k] = '0;
    end

    hpq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .lvl     (LVL_W'(k)),
      .count   (count_r),
      .in_tok  (cell_in[k]),
      .own_l   (rd_l[k]),
      .own_r   (rd_r[k]),
      .kid_l   (kid_l),
      .kid_r   (kid_r),
      .own_rd  (own_rd[k]),
      .kid_rd  (kid_rd[k]),
      .wr      (wr[k]),
      .out_tok (cell_out[k]),
      .done    (done_v[k])
    );

    assign busy_v[k] = cell_out[k].vld;
  end

  // Only one token travels down the chain at a time
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(busy_v))
    else $error("more than one level cell holds a token");

  // A cell finishes work only while the sequencer waits for it
  a_done_in_sift: assert property (@(posedge clk) disable iff (!rst_n)
    (|done_v) |-> (state_r == S_SIFT))
    else $error("level cell finished outside a sift");

  // Fill count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // A refused insert leaves the count alone and reports full
  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_tuser == OP_INSERT) && (count_r == CNT_W'(CAPACITY)))
      |=> (status_r == ST_FULL) && (count_r == $past(count_r)))
    else $error("insert into a full heap was not refused");

endmodule

`default_nettype wire

// ===== test/tb_max_heap_priority_queue_core.sv =====
// Self-checking testbench for the max-heap priority queue core with a software heap predictor.
`timescale 1ns / 1ps

module tb_max_heap_priority_queue_core;
  import hpq_pkg::*;

  // Expected contents of one result transfer
  typedef struct {
    val_t            removed;
    val_t            top;
    logic            top_vld;
    logic [10:0]     cnt;
    status_t         st;
  } heap_result_t;

  // Software heap plus the queue of results it predicts
  class heap_scoreboard;
    val_t         store [CAPACITY];
    int           fill;
    heap_result_t pending_results [$];
    int           mismatches;
    int           result_idx;

    function new();
      fill       = 0;
      mismatches = 0;
      result_idx = 0;
    endfunction

    task report_mismatch(string what);
      $display("mismatch at result %0d: %s", result_idx, what);
      mismatches++;
    endtask

    // Apply one accepted operation and queue the result it should produce
    function void note_operation(logic op, val_t v);
      heap_result_t r;
      int   pos;
      int   par;
      int   lc;
      int   rc;
      int   best;
      val_t t;
      r.removed = '0;
      r.st      = ST_OK;
      if (op == OP_INSERT) begin
        if (fill >= CAPACITY) begin
          r.st = ST_FULL;
        end else begin
          // Append, then bubble up past strictly smaller parents
          pos = fill;
          store[pos] = v;
          fill++;
          while (pos > 0) begin
            par = (pos - 1) / 2;
            if (!($signed(store[pos]) > $signed(store[par]))) break;
            t = store[pos]; store[pos] = store[par]; store[par] = t;
            pos = par;
          end
        end
      end else begin
        if (fill == 0) begin
          r.st = ST_EMPTY;
        end else begin
          // Take the root, move the last entry up and sink it
          r.removed = store[0];
          store[0] = store[fill - 1];
          fill--;
          pos = 0;
          forever begin
            lc   = 2 * pos + 1;
            rc   = 2 * pos + 2;
            best = pos;
            if (lc < fill && $signed(store[lc]) > $signed(store[best])) best = lc;
            if (rc < fill && $signed(store[rc]) > $signed(store[best])) best = rc;
            if (best == pos) break;
            t = store[pos]; store[pos] = store[best]; store[best] = t;
            pos = best;
          end
        end
      end
      r.top     = (fill != 0) ? store[0] : '0;
      r.top_vld = (fill != 0);
      r.cnt     = 11'(fill);
      pending_results.push_back(r);
    endfunction

    // Compare one result transfer against the oldest prediction
    task check_result(logic [OUT_TDATA_W-1:0] td, logic [OUT_TUSER_W-1:0] tu);
      heap_result_t e;
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        e = pending_results.pop_front();
        if (td[31:0] !== e.removed)
          report_mismatch($sformatf("removed_value got %h want %h", td[31:0], e.removed));
        if (td[63:32] !== e.top)
          report_mismatch($sformatf("top_value got %h want %h", td[63:32], e.top));
        if (td[74:64] !== e.cnt)
          report_mismatch($sformatf("element_count got %0d want %0d", td[74:64], e.cnt));
        if (td[79:75] !== 5'd0)
          report_mismatch($sformatf("tdata padding got %h", td[79:75]));
        if (tu[0] !== e.top_vld)
          report_mismatch($sformatf("top_valid got %b want %b", tu[0], e.top_vld));
        if (tu[2:1] !== e.st)
          report_mismatch($sformatf("status got %0d want %0d", tu[2:1], e.st));
      end
      result_idx++;
    endtask

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [DATA_W-1:0]      in_tdata   = '0;
  logic                   in_tuser   = OP_INSERT;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  heap_scoreboard sb = new();
  bit             calm = 1'b0;   // suppress idling on both sides
  int             rdy_hold = 0;

  max_heap_priority_queue_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Mix of extremes, a narrow band for equal keys, and full-range values
  function automatic val_t pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      1, 2, 3: return val_t'($urandom_range(0, 8)) - val_t'(4);
      default: return $urandom;
    endcase
  endfunction

  // Throttle the result side
  always @(posedge clk) begin
    if (rdy_hold > 0) begin
      rdy_hold   <= rdy_hold - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) rdy_hold <= gap_len();
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  // Offer one operation, wait for its transfer, then idle a while
  task send_op(logic op, val_t v);
    int g;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    sb.note_operation(op, v);
    g = calm ? 0 : gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task send_mixed(int remove_pct);
    send_op(($urandom_range(0, 99) < remove_pct) ? OP_REMOVE : OP_INSERT, pick_value());
  endtask

  initial begin
    int n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty remove, extremes, equal keys, drain past empty
    calm = 1'b1;
    send_op(OP_REMOVE, 32'h1234_5678);
    send_op(OP_INSERT, 32'h7FFF_FFFF);
    send_op(OP_INSERT, 32'h8000_0000);
    send_op(OP_INSERT, 32'h0000_0000);
    send_op(OP_INSERT, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 32'h0000_0001);
    send_op(OP_INSERT, 32'd5);
    send_op(OP_INSERT, 32'd5);
    send_op(OP_INSERT, 32'd5);
    send_op(OP_INSERT, 32'd7);
    repeat (4) send_op(OP_REMOVE, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 32'd3);
    send_op(OP_INSERT, 32'd3);
    repeat (8) send_op(OP_REMOVE, 32'h0000_0000);

    // Random walk near empty; first stretch without idling
    for (n = 0; n < 40; n++) begin
      calm = (n < 15);
      send_mixed(45);
    end
    calm = 1'b0;

    // Fill to capacity, push refused inserts, then mix near full
    while (sb.fill < CAPACITY) send_op(OP_INSERT, pick_value());
    repeat (4) send_op(OP_INSERT, pick_value());
    repeat (20) send_mixed(50);

    // Deep removes from a nearly full heap
    repeat (20) send_op(OP_REMOVE, pick_value());

    in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
design/hpq_pkg.sv
design/hpq_ram.sv
design/hpq_cell.sv
design/max_heap_priority_queue_core.sv
test/tb_max_heap_priority_queue_core.sv
